// File: design/gas_sensor_frame_receiver_unit_defines.svh
// assertion macros shared by the gas sensor frame receiver modules
`ifndef GAS_SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH
`define GAS_SENSOR_FRAME_RECEIVER_UNIT_DEFINES_SVH

// same-cycle implication, checked on clk, off while rst is high
`define GSFR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gsfr check failed");

// next-cycle implication, checked on clk, off while rst is high
`define GSFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gsfr check failed");

`endif

// File: design/gsfr_pkg.sv
// shared types and constants of the gas sensor frame receiver
package gsfr_pkg;

  // request codes
  localparam logic [1:0] REQ_BYTE     = 2'd0;
  localparam logic [1:0] REQ_TICK     = 2'd1;
  localparam logic [1:0] REQ_LINE_ERR = 2'd2;

  // sensor state codes
  localparam logic [1:0] ST_WARMUP = 2'd0;
  localparam logic [1:0] ST_VALID  = 2'd1;
  localparam logic [1:0] ST_STALE  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STALE  = 1'b1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [7:0]  START_MARK = 8'hFF;
  localparam logic [7:0]  HDR_ONE    = 8'h04;
  localparam logic [7:0]  HDR_TWO    = 8'h03;
  localparam int unsigned FRAME_LEN  = 9;
  localparam int unsigned HELD_MAX   = FRAME_LEN - 1;
  localparam int unsigned FILL_W     = 4;

  localparam logic [15:0] WARMUP_RESET = 16'd30000;
  localparam logic [15:0] STALE_RESET  = 16'd5000;

  localparam int unsigned COUNTER_BITS_DEF = 16;

  typedef struct packed {
    logic       fire;
    logic [1:0] req;
    logic [7:0] data;
  } step_t;

  typedef struct packed {
    logic        accepted;
    logic        rejected;
    logic [15:0] ppm;
  } frame_evt_t;

  typedef struct packed {
    logic [15:0] ppm;
    logic [1:0]  state;
    logic        new_reading;
    logic        rejected;
  } result_t;

endpackage

// File: design/gsfr_frame.sv
// frame assembly, header and checksum test, resync after a bad frame
`include "gas_sensor_frame_receiver_unit_defines.svh"

module gsfr_frame (
  input  logic                clk,
  input  logic                rst,
  input  gsfr_pkg::step_t     step,
  output gsfr_pkg::frame_evt_t evt
);

  logic [7:0]                  frame_bytes [gsfr_pkg::HELD_MAX];
  logic [7:0]                  frame_bytes_next [gsfr_pkg::HELD_MAX];
  logic [gsfr_pkg::FILL_W-1:0] fill_count;
  logic [gsfr_pkg::FILL_W-1:0] fill_count_next;

  logic [7:0]                  all_b [gsfr_pkg::FRAME_LEN];
  logic [7:0]                  sum;
  logic                        chk_ok;
  logic                        found;
  logic [gsfr_pkg::FILL_W-1:0] idx;
  logic [7:0]                  shifted [gsfr_pkg::HELD_MAX];
  logic [gsfr_pkg::FILL_W-1:0] keep;

  always_comb begin
    for (int k = 0; k < gsfr_pkg::HELD_MAX; k++) begin
      all_b[k] = frame_bytes[k];
    end
    all_b[gsfr_pkg::HELD_MAX] = step.data;
  end

  // bytes 1..8 summed: a good frame adds up to zero and carries the start mark and both header bytes
  always_comb begin
    sum = 8'd0;
    for (int k = 1; k < gsfr_pkg::FRAME_LEN; k++) begin
      sum = sum + all_b[k];
    end
    chk_ok = (all_b[0] == gsfr_pkg::START_MARK) && (all_b[1] == gsfr_pkg::HDR_ONE) &&
             (all_b[2] == gsfr_pkg::HDR_TWO) && (sum == 8'd0);
  end

  // first start mark after byte 0
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int k = 1; k < gsfr_pkg::FRAME_LEN; k++) begin
      if (!found && all_b[k] == gsfr_pkg::START_MARK) begin
        found = 1'b1;
        idx   = gsfr_pkg::FILL_W'(k);
      end
    end
    keep = gsfr_pkg::FILL_W'(gsfr_pkg::FRAME_LEN) - idx;
  end

  always_comb begin
    logic [gsfr_pkg::FILL_W:0] src;
    for (int j = 0; j < gsfr_pkg::HELD_MAX; j++) begin
      src = {1'b0, idx} + (gsfr_pkg::FILL_W + 1)'(j);
      if (src <= (gsfr_pkg::FILL_W + 1)'(gsfr_pkg::HELD_MAX)) begin
        shifted[j] = all_b[src[gsfr_pkg::FILL_W-1:0]];
      end else begin
        shifted[j] = frame_bytes[j];
      end
    end
  end

  always_comb begin
    frame_bytes_next = frame_bytes;
    fill_count_next  = fill_count;
    evt              = '0;
    if (step.fire) begin
      case (step.req)
        gsfr_pkg::REQ_BYTE: begin
          if (fill_count == '0) begin
            if (step.data == gsfr_pkg::START_MARK) begin
              frame_bytes_next[0] = step.data;
              fill_count_next     = gsfr_pkg::FILL_W'(1);
            end
          end else if (fill_count < gsfr_pkg::FILL_W'(gsfr_pkg::HELD_MAX)) begin
            frame_bytes_next[fill_count[2:0]] = step.data;
            fill_count_next = fill_count + gsfr_pkg::FILL_W'(1);
          end else if (chk_ok) begin
            evt.accepted    = 1'b1;
            evt.ppm         = {all_b[4], all_b[5]};
            fill_count_next = '0;
          end else begin
            evt.rejected = 1'b1;
            if (found) begin
              frame_bytes_next = shifted;
              fill_count_next  = keep;
            end else begin
              fill_count_next = '0;
            end
          end
        end
        gsfr_pkg::REQ_LINE_ERR: begin
          fill_count_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else begin
      fill_count <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    frame_bytes <= frame_bytes_next;
  end

  `GSFR_ASSERT_SAME(a_fill_bound, 1'b1, fill_count <= gsfr_pkg::FILL_W'(gsfr_pkg::HELD_MAX))
  `GSFR_ASSERT_NEXT(a_hunt_drop, step.fire && step.req == gsfr_pkg::REQ_BYTE && fill_count == '0 && step.data != gsfr_pkg::START_MARK, fill_count == '0)

endmodule

// File: design/gsfr_status.sv
// configuration, tick counters, latched reading and sensor state
`include "gas_sensor_frame_receiver_unit_defines.svh"

module gsfr_status #(
  parameter int unsigned COUNTER_BITS = gsfr_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [gsfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsfr_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  gsfr_pkg::step_t                  step,
  input  gsfr_pkg::frame_evt_t             evt,
  output gsfr_pkg::result_t                res
);

  logic [15:0]             warmup_ms;
  logic [15:0]             stale_ms;
  logic [15:0]             last_ppm;
  logic [15:0]             last_ppm_next;
  logic                    reading_seen;
  logic                    reading_seen_next;
  logic [COUNTER_BITS-1:0] reading_age;
  logic [COUNTER_BITS-1:0] reading_age_next;
  logic [COUNTER_BITS-1:0] uptime_count;
  logic [COUNTER_BITS-1:0] uptime_count_next;

  always_comb begin
    last_ppm_next     = last_ppm;
    reading_seen_next = reading_seen;
    reading_age_next  = reading_age;
    uptime_count_next = uptime_count;
    // saturating counters
    if (step.fire && step.req == gsfr_pkg::REQ_TICK) begin
      if (!(&uptime_count)) begin
        uptime_count_next = uptime_count + COUNTER_BITS'(1);
      end
      if (!(&reading_age)) begin
        reading_age_next = reading_age + COUNTER_BITS'(1);
      end
    end
    if (evt.accepted) begin
      last_ppm_next     = evt.ppm;
      reading_seen_next = 1'b1;
      reading_age_next  = '0;
    end

    res.ppm         = last_ppm_next;
    res.new_reading = evt.accepted;
    res.rejected    = evt.rejected;
    if (uptime_count_next < COUNTER_BITS'(warmup_ms)) begin
      res.state = gsfr_pkg::ST_WARMUP;
    end else if (reading_seen_next && reading_age_next <= COUNTER_BITS'(stale_ms)) begin
      res.state = gsfr_pkg::ST_VALID;
    end else begin
      res.state = gsfr_pkg::ST_STALE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warmup_ms    <= gsfr_pkg::WARMUP_RESET;
      stale_ms     <= gsfr_pkg::STALE_RESET;
      last_ppm     <= '0;
      reading_seen <= 1'b0;
      reading_age  <= '0;
      uptime_count <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gsfr_pkg::CFG_WARMUP: warmup_ms <= cfg_data;
          gsfr_pkg::CFG_STALE:  stale_ms  <= cfg_data;
          default: begin
          end
        endcase
      end
      last_ppm     <= last_ppm_next;
      reading_seen <= reading_seen_next;
      reading_age  <= reading_age_next;
      uptime_count <= uptime_count_next;
    end
  end

  `GSFR_ASSERT_NEXT(a_fresh_reading, evt.accepted, reading_seen && reading_age == '0)

endmodule

// File: design/gas_sensor_frame_receiver_unit.sv
// Gas sensor frame receiver: takes received bytes, millisecond ticks and
// line errors, assembles 9-byte frames that start with 0xFF, checks header and
// checksum, and returns one result per item with the latched ppm and the
// warming-up/valid/stale state. One item per clock sustained while out_ready
// stays high; each item passes the input register, then a single-pass update
// into the result register. in_ready follows out_ready through the one-entry
// input stage.
module gas_sensor_frame_receiver_unit #(
  parameter int unsigned COUNTER_BITS = gsfr_pkg::COUNTER_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      req_type,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     ppm,
  output logic [1:0]                      sensor_state,
  output logic                            new_reading,
  output logic                            frame_rejected,
  input  logic                            cfg_we,
  input  logic [gsfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gsfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic                 s1_valid;
  logic [1:0]           s1_req;
  logic [7:0]           s1_byte;
  logic                 advance;
  gsfr_pkg::step_t      step;
  gsfr_pkg::frame_evt_t evt;
  gsfr_pkg::result_t    res;
  gsfr_pkg::result_t    o_res;

  // the result register frees up when empty or when its transfer happens
  assign advance  = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;

  assign step.fire = s1_valid && advance;
  assign step.req  = s1_req;
  assign step.data = s1_byte;

  gsfr_frame u_frame (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .evt  (evt)
  );

  gsfr_status #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_status (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .evt       (evt),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_req  <= req_type;
      s1_byte <= rx_byte;
    end
    if (step.fire) begin
      o_res <= res;
    end
  end

  assign ppm            = o_res.ppm;
  assign sensor_state   = o_res.state;
  assign new_reading    = o_res.new_reading;
  assign frame_rejected = o_res.rejected;

endmodule
